// ----- rtl/core/fat32_offset_to_disk_address_macros.svh -----
// Assertion macros shared by the cluster walk RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef FAT32_OFFSET_TO_DISK_ADDRESS_MACROS_SVH
`define FAT32_OFFSET_TO_DISK_ADDRESS_MACROS_SVH

`ifndef SYNTHESIS
`define FATODA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FATODA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FATODA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FATODA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/fatoda_pkg.sv -----
// Shared constants and types of the FAT32 cluster walk block.
// No dependencies; imported by every module of the block.
package fatoda_pkg;

    localparam int DEF_TABLE_ENTRIES = 4096;

    localparam int DATA_W   = 32;
    localparam int DIVD_W   = 31;
    localparam int DIVS_W   = 32;
    localparam int MUL_B_W  = 13;
    localparam int CSIZE_W  = 21;
    localparam int EPOCH_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] END_MARK   = 32'h0FFF_FFF8;
    localparam logic [DATA_W-1:0] BAD_MARK   = 32'h0FFF_FFF7;
    localparam logic [DATA_W-1:0] RSV_MARK_A = 32'h0FFF_FFF0;
    localparam logic [DATA_W-1:0] RSV_MARK_B = 32'h0FFF_FFF6;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_END  = 3'd1;
    localparam logic [2:0] ST_BAD  = 3'd2;
    localparam logic [2:0] ST_RSV  = 3'd3;
    localparam logic [2:0] ST_FREE = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_PER_CLUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD_SECTORS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COPIES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_PER_TBL  = 3'd4;

    typedef struct packed {
        logic tbl_we;
        logic vis_we;
    } t_mem_ctl;

endpackage

// ----- rtl/core/fat32_offset_to_disk_address.sv -----
// Top level of the FAT32 cluster walk: sequencer, configuration registers, result register.
// Depends on fatoda_pkg, fatoda_div, fatoda_mac, fatoda_mem and the assertion macro header.
//
// Usage:
//   Input channel i_valid/o_ready carries one item per transfer. Opcode load writes one
//   table entry; opcode translate walks the cluster chain from i_start_cluster for
//   i_byte_offset / cluster size links and returns the cluster and its disk byte address.
//   Output channel o_valid/i_ready carries one result per item; the result register lets
//   the next item enter while a result waits, and a stalled receiver only holds the block
//   once a second result is finished.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; indexes
//   above the register list are dropped.
//   Steps: a load goes straight to the result register. A translate first divides the
//   byte offset by the cluster size in the serial divider for the link count, then reads
//   and checks the table once per link, and when the chain loops, divides once more by
//   the loop length and steps the remaining links. At most TABLE_ENTRIES distinct links
//   are walked before a loop is found.
//   Reset: a clearing pass over all TABLE_ENTRIES addresses zeroes the table and visit
//   marks; o_ready stays low meanwhile. Every 255 translates a pass over the addresses
//   renews the visit marks.
`include "fat32_offset_to_disk_address_macros.svh"

module fat32_offset_to_disk_address #(
    parameter int TABLE_ENTRIES = fatoda_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [11:0]                         i_entry_index,
    input  logic [31:0]                         i_entry_value,
    input  logic [27:0]                         i_start_cluster,
    input  logic [30:0]                         i_byte_offset,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0]                          o_status,
    output logic [31:0]                         o_found_cluster,
    output logic [31:0]                         o_disk_address,
    input  logic                                i_cfg_we,
    input  logic [fatoda_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                         i_cfg_data
);
    import fatoda_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int IW = $clog2(TABLE_ENTRIES + 1);
    localparam int VW = EPOCH_W + IW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CSIZE, S_DIVQ_GO, S_DIVQ, S_WALK_RD, S_WALK_CHK,
        S_DIVR, S_REST_RD, S_REST_NX, S_FIN1, S_FIN2, S_FIN3, S_RESULT
    } t_state;

    // configuration
    logic [12:0]       r_sb;
    logic [7:0]        r_spc;
    logic [15:0]       r_rsc;
    logic [7:0]        r_copies;
    logic [31:0]       r_spt;

    t_state            r_state;
    logic [AW-1:0]     r_clr;
    logic              r_clr_tbl;
    logic [EPOCH_W-1:0] r_epoch;
    logic              r_is_xlate;
    logic [DATA_W-1:0] r_cur;
    logic [30:0]       r_offset;
    logic [30:0]       r_within;
    logic [30:0]       r_remain;
    logic [IW-1:0]     r_i;
    logic [CSIZE_W-1:0] r_csize;
    logic [DATA_W-1:0] r_acc;
    logic [2:0]        r_status;

    logic [EPOCH_W-1:0] n_epoch;

    logic              in_xfer;
    logic              out_free;
    logic [31:0]       idx_ext;
    logic              idx_in_range;
    logic              cur_in_table;

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] tbl_wdata;
    logic [VW-1:0]     vis_wdata;
    logic [DATA_W-1:0] tbl_rdata;
    logic [VW-1:0]     vis_rdata;
    logic              vis_hit;
    logic [IW-1:0]     loop_len;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quot;
    logic [DIVS_W-1:0] div_rem;

    logic [DATA_W-1:0]  mac_a;
    logic [MUL_B_W-1:0] mac_b;
    logic [DATA_W-1:0]  mac_c;
    logic [DATA_W-1:0]  mac_res;

    assign o_ready      = (r_state == S_IDLE);
    assign in_xfer      = i_valid && o_ready;
    assign out_free     = !o_valid || i_ready;
    assign idx_ext      = 32'(i_entry_index);
    assign idx_in_range = idx_ext < 32'(TABLE_ENTRIES);
    assign cur_in_table = r_cur < 32'(TABLE_ENTRIES);
    assign vis_hit      = (vis_rdata[VW-1 -: EPOCH_W] == r_epoch);
    assign loop_len     = r_i - vis_rdata[IW-1:0];
    assign n_epoch      = r_epoch + 1'b1;

    always_comb begin
        mem_ctl.tbl_we = 1'b0;
        mem_ctl.vis_we = 1'b0;
        mem_waddr      = r_cur[AW-1:0];
        tbl_wdata      = '0;
        vis_wdata      = {r_epoch, r_i};
        unique case (r_state)
            S_CLEAR: begin
                mem_ctl.tbl_we = r_clr_tbl;
                mem_ctl.vis_we = 1'b1;
                mem_waddr      = r_clr;
                vis_wdata      = '0;
            end
            S_IDLE: begin
                mem_ctl.tbl_we = in_xfer && (i_opcode == OP_LOAD) && idx_in_range;
                mem_waddr      = idx_ext[AW-1:0];
                tbl_wdata      = i_entry_value;
            end
            S_WALK_CHK: begin
                mem_ctl.vis_we = !vis_hit;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_offset;
        div_divisor  = DIVS_W'(r_csize);
        if (r_state == S_DIVQ_GO && r_csize != '0) begin
            div_start = 1'b1;
        end else if (r_state == S_WALK_CHK && vis_hit) begin
            div_start    = 1'b1;
            div_dividend = r_remain;
            div_divisor  = DIVS_W'(loop_len);
        end
    end

    always_comb begin
        mac_a = 32'(r_sb);
        mac_b = MUL_B_W'(r_spc);
        mac_c = '0;
        unique case (r_state)
            S_FIN1: begin
                mac_a = r_spt;
                mac_b = MUL_B_W'(r_copies);
                mac_c = 32'(r_rsc);
            end
            S_FIN2: begin
                mac_a = r_cur - 32'd2;
                mac_b = MUL_B_W'(r_spc);
                mac_c = r_acc;
            end
            S_FIN3: begin
                mac_a = r_acc;
                mac_b = r_sb;
                mac_c = 32'(r_within);
            end
            default: begin
            end
        endcase
    end

    fatoda_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VW            (VW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_waddr     (mem_waddr),
        .i_tbl_wdata (tbl_wdata),
        .i_vis_wdata (vis_wdata),
        .i_raddr     (r_cur[AW-1:0]),
        .o_tbl_rdata (tbl_rdata),
        .o_vis_rdata (vis_rdata)
    );

    fatoda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    fatoda_mac u_mac (
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_res (mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb     <= 13'd512;
            r_spc    <= 8'd8;
            r_rsc    <= 16'd32;
            r_copies <= 8'd2;
            r_spt    <= 32'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SECTOR_BYTES: r_sb     <= i_cfg_data[12:0];
                CFG_SEC_PER_CLUS: r_spc    <= i_cfg_data[7:0];
                CFG_RSVD_SECTORS: r_rsc    <= i_cfg_data[15:0];
                CFG_TABLE_COPIES: r_copies <= i_cfg_data[7:0];
                CFG_SEC_PER_TBL:  r_spt    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_clr_tbl <= 1'b1;
            r_epoch   <= EPOCH_W'(1);
            o_valid   <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_RESULT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(TABLE_ENTRIES - 1)) begin
                        r_clr   <= '0;
                        r_epoch <= EPOCH_W'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_status   <= ST_OK;
                        r_is_xlate <= (i_opcode == OP_XLATE);
                        if (i_opcode == OP_LOAD) begin
                            r_cur   <= '0;
                            r_acc   <= '0;
                            r_state <= S_RESULT;
                        end else begin
                            r_cur    <= 32'(i_start_cluster);
                            r_offset <= i_byte_offset;
                            r_state  <= S_CSIZE;
                        end
                    end
                end
                S_CSIZE: begin
                    r_csize <= mac_res[CSIZE_W-1:0];
                    r_state <= S_DIVQ_GO;
                end
                S_DIVQ_GO: begin
                    r_i <= '0;
                    if (r_csize == '0) begin
                        r_remain <= '0;
                        r_within <= r_offset;
                        r_state  <= S_WALK_RD;
                    end else begin
                        r_state <= S_DIVQ;
                    end
                end
                S_DIVQ: begin
                    if (div_done) begin
                        r_remain <= div_quot;
                        r_within <= div_rem[30:0];
                        r_state  <= S_WALK_RD;
                    end
                end
                S_WALK_RD: begin
                    if (r_remain == '0) begin
                        r_state <= S_FIN1;
                    end else if (!cur_in_table) begin
                        r_status <= ST_END;
                        r_state  <= S_RESULT;
                    end else begin
                        r_state <= S_WALK_CHK;
                    end
                end
                S_WALK_CHK: begin
                    if (vis_hit) begin
                        r_state <= S_DIVR;
                    end else begin
                        priority if (tbl_rdata >= END_MARK) begin
                            r_status <= ST_END;
                            r_state  <= S_RESULT;
                        end else if (tbl_rdata == BAD_MARK) begin
                            r_status <= ST_BAD;
                            r_state  <= S_RESULT;
                        end else if (tbl_rdata == RSV_MARK_A || tbl_rdata == RSV_MARK_B) begin
                            r_status <= ST_RSV;
                            r_state  <= S_RESULT;
                        end else if (tbl_rdata == '0) begin
                            r_status <= ST_FREE;
                            r_state  <= S_RESULT;
                        end else begin
                            r_cur    <= tbl_rdata;
                            r_i      <= r_i + 1'b1;
                            r_remain <= r_remain - 1'b1;
                            r_state  <= S_WALK_RD;
                        end
                    end
                end
                S_DIVR: begin
                    if (div_done) begin
                        r_remain <= div_rem[30:0];
                        r_state  <= S_REST_RD;
                    end
                end
                S_REST_RD: begin
                    if (r_remain == '0) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_state <= S_REST_NX;
                    end
                end
                S_REST_NX: begin
                    r_cur    <= tbl_rdata;
                    r_remain <= r_remain - 1'b1;
                    r_state  <= S_REST_RD;
                end
                S_FIN1: begin
                    r_acc   <= mac_res;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_acc   <= mac_res;
                    r_state <= S_FIN3;
                end
                S_FIN3: begin
                    r_acc   <= mac_res;
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        o_valid  <= 1'b1;
                        o_status <= r_status;
                        if (r_status == ST_OK) begin
                            o_found_cluster <= r_cur;
                            o_disk_address  <= r_acc;
                        end else begin
                            o_found_cluster <= '0;
                            o_disk_address  <= '0;
                        end
                        if (r_is_xlate) begin
                            r_epoch <= n_epoch;
                        end
                        if (r_is_xlate && n_epoch == '0) begin
                            r_clr     <= '0;
                            r_clr_tbl <= 1'b0;
                            r_state   <= S_CLEAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `FATODA_ASSERT_IMP(a_walk_in_table, i_clk, i_rst_n, r_state == S_WALK_CHK, cur_in_table)
    `FATODA_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_found_cluster == '0 && o_disk_address == '0)
    `FATODA_ASSERT_NXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_ready)

endmodule

// ----- rtl/core/fatoda_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on fatoda_pkg and the assertion macro header.
`include "fat32_offset_to_disk_address_macros.svh"

module fatoda_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fatoda_pkg::DIVD_W-1:0] i_dividend,
    input  logic [fatoda_pkg::DIVS_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [fatoda_pkg::DIVD_W-1:0] o_quot,
    output logic [fatoda_pkg::DIVS_W-1:0] o_rem
);
    import fatoda_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIVS_W-1:0]   r_rem;
    logic [DIVS_W-1:0]   r_dvs;
    logic [DIVD_W-1:0]   r_quot;

    logic [DIVS_W:0]     trial;
    logic                fits;

    assign trial = {r_rem, r_quot[DIVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quot <= i_dividend;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= DIVS_W'(trial - {1'b0, r_dvs});
                end else begin
                    r_rem <= trial[DIVS_W-1:0];
                end
                r_quot <= {r_quot[DIVD_W-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    `FATODA_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, i_start, !r_busy)
    `FATODA_ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_done, r_rem < r_dvs)

endmodule

// ----- rtl/core/fatoda_mac.sv -----
// Shared multiply-add unit: low 32 bits of a * b + c.
// Depends on fatoda_pkg.
module fatoda_mac (
    input  logic [fatoda_pkg::DATA_W-1:0]  i_a,
    input  logic [fatoda_pkg::MUL_B_W-1:0] i_b,
    input  logic [fatoda_pkg::DATA_W-1:0]  i_c,
    output logic [fatoda_pkg::DATA_W-1:0]  o_res
);
    import fatoda_pkg::*;

    logic [DATA_W+MUL_B_W-1:0] prod;

    assign prod  = {{MUL_B_W{1'b0}}, i_a} * {{DATA_W{1'b0}}, i_b};
    assign o_res = prod[DATA_W-1:0] + i_c;

endmodule

// ----- rtl/core/fatoda_mem.sv -----
// Allocation table memory and visit mark memory, one write and one read port each.
// Depends on fatoda_pkg; read data is registered.
module fatoda_mem #(
    parameter int TABLE_ENTRIES = fatoda_pkg::DEF_TABLE_ENTRIES,
    parameter int VW            = fatoda_pkg::EPOCH_W + $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                                  i_clk,
    input  fatoda_pkg::t_mem_ctl                  i_ctl,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]      i_waddr,
    input  logic [fatoda_pkg::DATA_W-1:0]         i_tbl_wdata,
    input  logic [VW-1:0]                         i_vis_wdata,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]      i_raddr,
    output logic [fatoda_pkg::DATA_W-1:0]         o_tbl_rdata,
    output logic [VW-1:0]                         o_vis_rdata
);
    import fatoda_pkg::*;

    logic [DATA_W-1:0] r_tbl [TABLE_ENTRIES];
    logic [VW-1:0]     r_vis [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.tbl_we) begin
            r_tbl[i_waddr] <= i_tbl_wdata;
        end
        o_tbl_rdata <= r_tbl[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vis_we) begin
            r_vis[i_waddr] <= i_vis_wdata;
        end
        o_vis_rdata <= r_vis[i_raddr];
    end

endmodule
